// File: hdl/key_to_index_set_macros.svh
// Assertion macros shared by the checker of key_to_index_set.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef KEY_TO_INDEX_SET_MACROS_SVH
`define KEY_TO_INDEX_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/kis_pkg.sv
`timescale 1ns / 1ps

package kis_pkg;

	localparam int KEY_W        = 32;
	localparam int INDEX_W      = 6;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

	// Bit positions in the result on the master side.
	localparam int M_IDX_LSB   = 0;
	localparam int M_CNT_LSB   = INDEX_W;
	localparam int M_FOUND_BIT = 0;
	localparam int M_FULL_BIT  = 1;

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	// Search token that travels down the row of cells.
	typedef struct packed {
		logic             valid;
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		logic             hit;
	} tok_t;

	// Broadcast store write from the tail of the row.
	typedef struct packed {
		logic             en;
		logic [KEY_W-1:0] key;
	} wr_t;

endpackage

// File: hdl/kis_cell.sv
`timescale 1ns / 1ps

module kis_cell #(
	parameter int SLOT  = 0,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kis_pkg::tok_t       tok_in,
	input  logic [IDX_W-1:0]    idx_in,
	input  logic [CNT_W-1:0]    count,
	input  kis_pkg::wr_t        wr,
	input  logic [IDX_W-1:0]    wr_slot,
	output kis_pkg::tok_t       tok_out,
	output logic [IDX_W-1:0]    idx_out
);

	logic [kis_pkg::KEY_W-1:0] key_q;
	logic                      valid_q;
	kis_pkg::tok_t             tok_q;
	kis_pkg::tok_t             tok_nxt;
	logic [IDX_W-1:0]          idx_q;
	logic                      occupied;
	logic                      match;

	// The slot holds a live key only while it lies below the entry count.
	assign occupied = CNT_W'(SLOT) < count;
	assign match    = tok_in.valid && !tok_in.hit && occupied && (key_q == tok_in.key);

	always_comb begin
		tok_nxt     = tok_in;
		tok_nxt.hit = tok_in.hit || match;
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr_slot == IDX_W'(SLOT))) begin
			key_q <= wr.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		idx_q <= match ? IDX_W'(SLOT) : idx_in;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

	assign idx_out = idx_q;

endmodule

// File: hdl/key_to_index_set.sv
// A search token walks the row of key cells one slot per cycle; its result then passes a
// holding register into the output register on the master side. Only one request is in
// flight: the next request enters once the previous result has reached the output register.
// Reset: arst_n clears the entry count and all handshake state; stored keys are not
// cleared, since a slot is only compared while it lies below the entry count.
`timescale 1ns / 1ps

module key_to_index_set #(
	parameter int CAPACITY = kis_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Command side.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kis_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] key
	input  logic [kis_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] cmd
	// Result side.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kis_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] index, [12:6] count, [15:13] 0
	output logic [kis_pkg::M_TUSER_W-1:0]   m_tuser    // [0] found, [1] full_res
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// The chain of cells. Each cell owns one slot of the key store and compares its
	// key against the token as it passes; the first occupied slot that matches marks
	// the token as a hit and stamps its slot number. Entry 0 is the token that enters
	// on an accepted request, entry CAPACITY is what leaves the last cell.
	kis_pkg::tok_t    tok_c [0:CAPACITY];
	logic [IDX_W-1:0] idx_c [0:CAPACITY];

	kis_pkg::wr_t     wr;
	logic [IDX_W-1:0] wr_slot;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	logic accept;
	logic busy_q;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	assign tok_c[0] = '{
		valid: accept,
		cmd:   kis_pkg::cmd_t'(s_tuser[0]),
		key:   s_tdata[kis_pkg::KEY_W-1:0],
		hit:   1'b0
	};
	assign idx_c[0] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
		kis_cell #(
			.SLOT  (g),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_c[g]),
			.idx_in  (idx_c[g]),
			.count   (count_q),
			.wr      (wr),
			.wr_slot (wr_slot),
			.tok_out (tok_c[g+1]),
			.idx_out (idx_c[g+1])
		);
	end

	// When the token leaves the last cell, every occupied slot has been compared.
	// A miss on an insert appends the key at the slot named by the entry count,
	// unless the table is already full, in which case the key is dropped and the
	// full flag goes out instead. Only one request is in flight, so the store and
	// the count are settled before the next token enters the row.
	kis_pkg::tok_t    tail;
	logic [IDX_W-1:0] tail_idx;
	logic             miss_ins;
	logic             room;
	logic [IDX_W-1:0] res_idx;
	logic             res_full;

	assign tail     = tok_c[CAPACITY];
	assign tail_idx = idx_c[CAPACITY];
	assign miss_ins = tail.valid && !tail.hit && (tail.cmd == kis_pkg::CMD_INSERT);
	assign room     = count_q < CNT_W'(CAPACITY);

	always_comb begin
		wr.en  = miss_ins && room;
		wr.key = tail.key;
	end
	assign wr_slot   = count_q[IDX_W-1:0];
	assign count_nxt = count_q + CNT_W'(wr.en);
	assign res_full  = miss_ins && !room;
	assign res_idx   = tail.hit ? tail_idx : (wr.en ? count_q[IDX_W-1:0] : '0);

	// Index and count are reported in their low bits only when the capacity runs past
	// the field widths; narrower internal values are zero-extended.
	logic [kis_pkg::INDEX_W+IDX_W-1:0] idx_wide;
	logic [kis_pkg::COUNT_W+CNT_W-1:0] cnt_wide;

	assign idx_wide = {{kis_pkg::INDEX_W{1'b0}}, res_idx};
	assign cnt_wide = {{kis_pkg::COUNT_W{1'b0}}, count_nxt};

	// The result as it goes out on the master side, with the unused tdata bits at zero.
	logic [kis_pkg::M_TDATA_W-1:0] res_data;
	logic [kis_pkg::M_TUSER_W-1:0] res_user;

	always_comb begin
		res_data = '0;
		res_data[kis_pkg::M_IDX_LSB +: kis_pkg::INDEX_W] = idx_wide[kis_pkg::INDEX_W-1:0];
		res_data[kis_pkg::M_CNT_LSB +: kis_pkg::COUNT_W] = cnt_wide[kis_pkg::COUNT_W-1:0];
		res_user = '0;
		res_user[kis_pkg::M_FOUND_BIT] = tail.hit;
		res_user[kis_pkg::M_FULL_BIT]  = res_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr.en) begin
			count_q <= count_nxt;
		end
	end

	// The finished result waits in a holding register so that it can leave the row
	// even while the previous result is still stalled on the master side.
	logic                          pend_valid_q;
	logic [kis_pkg::M_TDATA_W-1:0] pend_data_q;
	logic [kis_pkg::M_TUSER_W-1:0] pend_user_q;
	logic                          m_tvalid_q;
	logic [kis_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [kis_pkg::M_TUSER_W-1:0] m_tuser_q;
	logic                          out_load;

	assign out_load = pend_valid_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			pend_data_q <= res_data;
			pend_user_q <= res_user;
		end
		if (out_load) begin
			m_tdata_q <= pend_data_q;
			m_tuser_q <= pend_user_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			if (tail.valid) begin
				pend_valid_q <= 1'b1;
			end else if (out_load) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// A request owns the row from acceptance until its result reaches the
			// output register.
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: hdl/kis_checker.sv
`timescale 1ns / 1ps
`include "key_to_index_set_macros.svh"

module kis_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [kis_pkg::S_TDATA_W-1:0]   s_tdata,
	input logic [kis_pkg::S_TUSER_W-1:0]   s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [kis_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [kis_pkg::M_TUSER_W-1:0]   m_tuser
);

	logic stalled;
	logic found;
	logic full_res;
	logic s_seen;

	assign stalled  = m_tvalid && !m_tready;
	assign found    = m_tuser[kis_pkg::M_FOUND_BIT];
	assign full_res = m_tuser[kis_pkg::M_FULL_BIT];
	assign s_seen   = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

	// A stalled result keeps its payload.
	`KIS_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	// A key that was found can never have been dropped for lack of room.
	`KIS_ASSERT_NOW(a_found_full, m_tvalid, !(found && full_res), "found and full both set")
	// A dropped insert reports slot zero.
	`KIS_ASSERT_NOW(a_full_idx, m_tvalid && full_res, m_tdata[kis_pkg::M_IDX_LSB +: kis_pkg::INDEX_W] == '0, "dropped insert with nonzero index")
	// Only one request is in the row at a time.
	`KIS_ASSERT_NEXT(a_one_req, s_seen, !s_tready, "second request accepted back to back")

endmodule

bind key_to_index_set kis_checker u_kis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import kis_pkg::*;

	// The block is built at its default size, so index and count fit their fields.
	localparam int CAPACITY     = kis_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1528;
	// Each request walks the row of cells and may also wait out a sender gap and a receiver
	// stall. The limit is many times what one request takes.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 2 * (CAPACITY + 2) + 16;
	localparam int PAD_LSB      = M_CNT_LSB + COUNT_W;

	// One result as the block reports it, unpacked into its fields.
	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] index;
		logic               full_res;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	// One row of the directed part. When typed is set, the result is written
	// into the row by hand; otherwise it comes from the predictor.
	typedef struct {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		bit               typed;
		outcome_t         result;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;   // [31:0] key
	logic [S_TUSER_W-1:0]  s_tuser = '0;   // [0] cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;        // [5:0] index, [12:6] count, [15:13] 0
	logic [M_TUSER_W-1:0]  m_tuser;        // [0] found, [1] full_res

	// Our own copy of the set: keys in insertion order and how many are held.
	logic [KEY_W-1:0] held_keys [CAPACITY];
	int unsigned      held_n = 0;

	outcome_t    expected_results [$];
	dir_row_t    dir_rows [$];
	int unsigned mismatches = 0;
	int unsigned cycle_cnt = 0;
	// Random idling on both sides is allowed while this is set.
	bit          idling = 1'b1;
	int unsigned ready_hold = 0;

	key_to_index_set #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor of the set. The stored slots are searched from the lowest up; an
	// absent key is appended on insert while there is room, and dropped with the
	// full flag once the table holds CAPACITY keys. A lookup never changes state.
	function automatic void apply_to_set(input cmd_t c, input logic [KEY_W-1:0] k,
			output outcome_t r);
		int unsigned slot;
		bit          hit;
		hit  = 1'b0;
		slot = 0;
		for (int unsigned i = 0; i < held_n; i++) begin
			if (!hit && held_keys[i] == k) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		r.found    = hit;
		r.full_res = 1'b0;
		if (!hit && c == CMD_INSERT) begin
			if (held_n < CAPACITY) begin
				slot              = held_n;
				held_keys[held_n] = k;
				held_n++;
			end else begin
				r.full_res = 1'b1;
			end
		end
		r.index = INDEX_W'(slot);
		r.count = COUNT_W'(held_n);
	endfunction

	// Prints one line per mismatch (the first hundred) and counts every one.
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at cycle %0d: %s got %0d, expected %0d",
				cycle_cnt, what, got, want);
	endtask

	function automatic void add_row(input cmd_t c, input logic [KEY_W-1:0] k, input bit typed,
			input logic found, input int unsigned index, input logic full_res,
			input int unsigned count);
		dir_row_t row;
		row.cmd             = c;
		row.key             = k;
		row.typed           = typed;
		row.result.found    = found;
		row.result.index    = INDEX_W'(index);
		row.result.full_res = full_res;
		row.result.count    = COUNT_W'(count);
		dir_rows.push_back(row);
	endfunction

	// Offers one request, optionally after an idle burst, and holds it until the
	// block takes it. The expected result is queued at the accepting edge.
	task automatic send_request(input cmd_t c, input logic [KEY_W-1:0] k, input bit typed,
			input outcome_t typed_result);
		outcome_t    predicted;
		int unsigned gap;
		if (idling && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= k;
		s_tuser  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_to_set(c, k, predicted);
		expected_results.push_back(typed ? typed_result : predicted);
	endtask

	// The receiver stalls in random bursts between ready stretches
	// of random length; with idling off it is always ready.
	always @(negedge clk) begin
		if (!idling) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if (m_tready && $urandom_range(3) == 0) begin
			m_tready   <= 1'b0;
			ready_hold = $urandom_range(0, 11);
		end else begin
			m_tready   <= 1'b1;
			ready_hold = $urandom_range(0, 30);
		end
	end

	// Every result taken is matched field by field against the oldest expectation.
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with none outstanding, tdata", m_tdata, 0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[M_FOUND_BIT] !== want.found)
					report_mismatch("found", m_tuser[M_FOUND_BIT], want.found);
				if (m_tdata[M_IDX_LSB +: INDEX_W] !== want.index)
					report_mismatch("index", m_tdata[M_IDX_LSB +: INDEX_W], want.index);
				if (m_tuser[M_FULL_BIT] !== want.full_res)
					report_mismatch("full_res", m_tuser[M_FULL_BIT], want.full_res);
				if (m_tdata[M_CNT_LSB +: COUNT_W] !== want.count)
					report_mismatch("count", m_tdata[M_CNT_LSB +: COUNT_W], want.count);
				if (m_tdata[M_TDATA_W-1:PAD_LSB] !== '0)
					report_mismatch("tdata padding", m_tdata[M_TDATA_W-1:PAD_LSB], 0);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("key_to_index_set regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] k;
		cmd_t             c;
		int unsigned      pick;
		int unsigned      ins_pct;
		int unsigned      held_pct;
		outcome_t         none;
		none = '0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. After reset the set is empty, so the first rows can be
		// read off by hand: extreme keys, an insert of a key already present, a
		// lookup of an absent key, and the all-ones pattern. The later rows probe
		// keys one bit apart and alternating patterns against the predictor.
		// The full-table case needs CAPACITY inserts and is reached in the
		// random fill below.
		add_row(CMD_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0, 0);
		add_row(CMD_LOOKUP, 32'h8000_0000, 1'b1, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'h8000_0000, 1'b1, 1'b0, 0, 1'b0, 1);
		add_row(CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 1'b0, 1, 1'b0, 2);
		add_row(CMD_INSERT, 32'h8000_0000, 1'b1, 1'b1, 0, 1'b0, 2);
		add_row(CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1, 1'b1, 1, 1'b0, 2);
		add_row(CMD_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0, 2);
		add_row(CMD_INSERT, 32'h0000_0000, 1'b1, 1'b0, 2, 1'b0, 3);
		add_row(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 3, 1'b0, 4);
		add_row(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, 3, 1'b0, 4);
		add_row(CMD_LOOKUP, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'h7FFF_FFFE, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'h8000_0001, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_LOOKUP, 32'h8000_0001, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_LOOKUP, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'h5555_5555, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_LOOKUP, 32'hAAAA_AAAA, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_INSERT, 32'h5555_5555, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_LOOKUP, 32'hAAAA_AAAB, 1'b0, 1'b0, 0, 1'b0, 0);
		add_row(CMD_LOOKUP, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0, 0);
		foreach (dir_rows[i])
			send_request(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].result);

		// Random part. During the fill phase inserts are rarer, so the table
		// grows slowly through every index while lookups and repeated inserts
		// hit the stored keys. Afterwards the table is full and absent keys are
		// dropped. Keys mix stored keys, near misses one bit away from a stored
		// key, corner patterns and fully random values.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				idling = ($urandom_range(3) != 0);
			if (i >= RANDOM_ITEMS - 150)
				idling = 1'b0;
			ins_pct  = (i < 800) ? 25 : 50;
			held_pct = (i < 800) ? 50 : 40;
			c = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_LOOKUP;
			pick = $urandom_range(99);
			if (held_n > 0 && pick < held_pct) begin
				k = held_keys[$urandom_range(held_n - 1)];
			end else if (held_n > 0 && pick < held_pct + 10) begin
				k = held_keys[$urandom_range(held_n - 1)] ^ (32'h1 << $urandom_range(31));
			end else if (pick < held_pct + 20) begin
				case ($urandom_range(6))
					0: k = 32'h0000_0000;
					1: k = 32'h0000_0001;
					2: k = 32'hFFFF_FFFF;
					3: k = 32'h8000_0000;
					4: k = 32'h7FFF_FFFF;
					5: k = 32'h1 << $urandom_range(31);
					default: k = ~(32'h1 << $urandom_range(31));
				endcase
			end else begin
				k = $urandom;
			end
			send_request(c, k, 1'b0, none);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain: every result must arrive, then a quiet spell catches extras.
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("key_to_index_set regression: pass");
		end else begin
			$display("key_to_index_set regression: fail");
		end
		$finish;
	end

endmodule
